// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ISB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define ISB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/isb_pkg.sv =====
`default_nettype none
package isb_pkg;
    localparam int MAX_WIDTH      = 256;
    localparam int MAX_HEIGHT     = 256;
    localparam int ROUNDS         = 3;
    localparam int COMPONENT_BITS = 32;

    localparam int X_BITS     = $clog2(MAX_WIDTH);
    localparam int Y_BITS     = $clog2(MAX_HEIGHT);
    localparam int ADDR_BITS  = X_BITS + Y_BITS;
    localparam int PIX_BITS   = 3 * COMPONENT_BITS;
    localparam int SIZE_BITS  = 9;
    localparam int WEIGHT_BITS = 16;
    localparam int ROUND_BITS = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int SUM_BITS   = COMPONENT_BITS + 1;
    localparam int PROD_BITS  = SUM_BITS + WEIGHT_BITS;
    localparam int NUM_BITS   = PROD_BITS + 1;
    localparam int DEN_BITS   = WEIGHT_BITS + 2;
    localparam int DIV_BITS   = $clog2(COMPONENT_BITS);
    localparam int CENTRE_SHIFT = 12;

    localparam logic [DEN_BITS-1:0] CENTRE_TAP = DEN_BITS'(4096);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(4096);
    localparam logic [SIZE_BITS-1:0] WIDTH_MAX_SZ  = SIZE_BITS'(MAX_WIDTH);
    localparam logic [SIZE_BITS-1:0] HEIGHT_MAX_SZ = SIZE_BITS'(MAX_HEIGHT);

    typedef enum logic [1:0] {
        REG_WEIGHT = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_index;

    typedef enum logic [0:0] {
        FUNC_LOAD  = 1'b0,
        FUNC_FETCH = 1'b1
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_OUT, S_B_RD0, S_B_RD1, S_B_RD2, S_B_RD3,
        S_B_MUL, S_B_WAIT, S_B_WR
    } t_state;

    typedef enum logic [1:0] {
        T_IDLE, T_MUL, T_ADD, T_DIV
    } t_tap_state;

    typedef struct packed {
        logic start;
        logic hp;
        logic hq;
    } t_tap_req;

    function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                        input logic [SIZE_BITS-1:0] maxv);
        logic [SIZE_BITS-1:0] r;
        r = v;
        if (v < SIZE_BITS'(2)) r = SIZE_BITS'(2);
        else if (v > maxv) r = maxv;
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/isb_if.sv =====
`default_nettype none
interface isb_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   func;
    logic [isb_pkg::COMPONENT_BITS-1:0]     in_red;
    logic [isb_pkg::COMPONENT_BITS-1:0]     in_green;
    logic [isb_pkg::COMPONENT_BITS-1:0]     in_blue;
    modport source (output valid, func, in_red, in_green, in_blue, input ready);
    modport sink (input valid, func, in_red, in_green, in_blue, output ready);
endinterface

interface isb_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [isb_pkg::COMPONENT_BITS-1:0]     out_red;
    logic [isb_pkg::COMPONENT_BITS-1:0]     out_green;
    logic [isb_pkg::COMPONENT_BITS-1:0]     out_blue;
    logic                                   last_pixel;
    logic                                   frame_ready;
    modport source (output valid, out_red, out_green, out_blue, last_pixel, frame_ready,
                    input ready);
    modport sink (input valid, out_red, out_green, out_blue, last_pixel, frame_ready,
                  output ready);
endinterface

interface isb_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             index;
    logic [isb_pkg::WEIGHT_BITS-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/isb_ram.sv =====
`default_nettype none
module isb_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [isb_pkg::ADDR_BITS-1:0] i_waddr,
    input  wire logic [isb_pkg::PIX_BITS-1:0]  i_wdata,
    input  wire logic [isb_pkg::ADDR_BITS-1:0] i_raddr,
    output logic      [isb_pkg::PIX_BITS-1:0]  o_rdata
);
    import isb_pkg::*;

    logic [PIX_BITS-1:0] r_mem [1 << ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/isb_tap.sv =====
`default_nettype none
module isb_tap (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire isb_pkg::t_tap_req                  i_req,
    input  wire logic [isb_pkg::WEIGHT_BITS-1:0]    i_weight,
    input  wire logic [isb_pkg::COMPONENT_BITS-1:0] i_p,
    input  wire logic [isb_pkg::COMPONENT_BITS-1:0] i_m,
    input  wire logic [isb_pkg::COMPONENT_BITS-1:0] i_q,
    output logic                                    o_done,
    output logic      [isb_pkg::COMPONENT_BITS-1:0] o_result
);
    import isb_pkg::*;

    t_tap_state r_state, n_state;
    logic [SUM_BITS-1:0]       r_sum;
    logic [PROD_BITS-1:0]      r_prod;
    logic [COMPONENT_BITS-1:0] r_m;
    logic [DEN_BITS-1:0]       r_den;
    logic [DEN_BITS-1:0]       r_rem;
    logic [COMPONENT_BITS-1:0] r_lo;
    logic [DIV_BITS-1:0]       r_cnt;
    logic                      r_done;
    logic [NUM_BITS-1:0]       num;
    logic [DEN_BITS:0]         trial;
    logic                      fits;

    assign num = NUM_BITS'(r_prod) + (NUM_BITS'(r_m) << CENTRE_SHIFT)
               + NUM_BITS'(r_den >> 1);
    assign trial = {r_rem, r_lo[COMPONENT_BITS-1]};
    assign fits = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_result = r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: if (i_req.start) n_state = T_MUL;
            T_MUL:  n_state = T_ADD;
            T_ADD:  n_state = T_DIV;
            T_DIV:  if (r_cnt == DIV_BITS'(COMPONENT_BITS - 1)) n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == T_DIV) && (r_cnt == DIV_BITS'(COMPONENT_BITS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            T_IDLE: begin
                r_sum <= (i_req.hp ? SUM_BITS'(i_p) : '0) + (i_req.hq ? SUM_BITS'(i_q) : '0);
                r_den <= CENTRE_TAP + (i_req.hp ? DEN_BITS'(i_weight) : '0)
                       + (i_req.hq ? DEN_BITS'(i_weight) : '0);
                r_m   <= i_m;
            end
            T_MUL: begin
                r_prod <= PROD_BITS'(r_sum) * PROD_BITS'(i_weight);
            end
            T_ADD: begin
                r_rem <= num[NUM_BITS-1:COMPONENT_BITS];
                r_lo  <= num[COMPONENT_BITS-1:0];
                r_cnt <= '0;
            end
            T_DIV: begin
                r_rem <= fits ? DEN_BITS'(trial - {1'b0, r_den}) : trial[DEN_BITS-1:0];
                r_lo  <= {r_lo[COMPONENT_BITS-2:0], fits};
                r_cnt <= r_cnt + DIV_BITS'(1);
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/iterated_separable_blur_3x3_core.sv =====
`default_nettype none
// Loads a frame of RGB pixels (Q16.16 components) in raster order, one word per cycle
// while the block is idle and no register write is pending. The word that completes
// the frame starts three rounds of a separable 3-tap blur; each round filters all rows
// into a scratch memory and then all columns back into the frame memory. Every output
// pixel reads three neighbors from a single memory port, then each of its three
// components passes through one shared tap unit: a 33x16 multiply, an add and a
// 32-step restoring divider. No input word is accepted while the blur runs. A fetch
// reads the next pixel from the frame memory into an output register and presents it
// until it is taken; when no blurred frame exists, zeros are presented instead.
// Register writes are taken only while the block is idle, and a pending register write
// holds off input words.
module iterated_separable_blur_3x3_core (
    input wire logic i_clk,
    input wire logic i_rst_n,
    isb_in_if.sink   i_in,
    isb_out_if.source o_out,
    isb_cfg_if.sink  i_cfg
);
    import isb_pkg::*;
    `include "assert_macros.svh"

    t_state r_state, n_state;

    logic [WEIGHT_BITS-1:0] r_weight;
    logic [SIZE_BITS-1:0]   r_width, r_height;
    logic [X_BITS-1:0]      r_lx, r_rx, r_bx;
    logic [Y_BITS-1:0]      r_ly, r_ry, r_by;
    logic                   r_valid;
    logic                   r_pass;
    logic [ROUND_BITS-1:0]  r_round;
    logic [1:0]             r_comp;
    logic [PIX_BITS-1:0]    r_p, r_m, r_q;
    logic [COMPONENT_BITS-1:0] r_res [3];
    logic [PIX_BITS-1:0]    r_out;
    logic                   r_last, r_ready_flag;

    logic in_acc, cfg_acc, load_acc, fetch_acc;
    logic lx_end, ly_end, rx_end, ry_end, bx_end, by_end;
    logic hp, hq;
    logic [ADDR_BITS-1:0] mid_addr, prev_addr, next_addr, rd_addr;
    logic [ADDR_BITS-1:0] frame_raddr, frame_waddr;
    logic [PIX_BITS-1:0]  frame_rdata, scratch_rdata, src_data, frame_wdata, res_pix;
    logic frame_we, scratch_we;
    t_tap_req tap_req;
    logic tap_done;
    logic [COMPONENT_BITS-1:0] tap_res, tp, tm, tq;
    logic [1:0] comp_sel;

    assign in_acc    = i_in.valid && i_in.ready;
    assign cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign load_acc  = in_acc && (i_in.func == FUNC_LOAD);
    assign fetch_acc = in_acc && (i_in.func == FUNC_FETCH);
    assign i_in.ready  = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = (r_state == S_IDLE);

    assign lx_end = {1'b0, r_lx} == r_width - SIZE_BITS'(1);
    assign ly_end = {1'b0, r_ly} == r_height - SIZE_BITS'(1);
    assign rx_end = {1'b0, r_rx} == r_width - SIZE_BITS'(1);
    assign ry_end = {1'b0, r_ry} == r_height - SIZE_BITS'(1);
    assign bx_end = {1'b0, r_bx} == r_width - SIZE_BITS'(1);
    assign by_end = {1'b0, r_by} == r_height - SIZE_BITS'(1);

    assign hp = r_pass ? (r_by != '0) : (r_bx != '0);
    assign hq = r_pass ? !by_end : !bx_end;

    assign mid_addr  = {r_by, r_bx};
    assign prev_addr = r_pass ? {r_by - Y_BITS'(1), r_bx} : {r_by, r_bx - X_BITS'(1)};
    assign next_addr = r_pass ? {r_by + Y_BITS'(1), r_bx} : {r_by, r_bx + X_BITS'(1)};

    always_comb begin
        case (r_state)
            S_B_RD1: rd_addr = prev_addr;
            S_B_RD2: rd_addr = next_addr;
            default: rd_addr = mid_addr;
        endcase
    end

    assign frame_raddr = (r_state == S_IDLE) ? {r_ry, r_rx} : rd_addr;
    assign src_data    = r_pass ? scratch_rdata : frame_rdata;
    assign res_pix     = {r_res[0], r_res[1], r_res[2]};
    assign frame_we    = load_acc || ((r_state == S_B_WR) && r_pass);
    assign frame_waddr = load_acc ? {r_ly, r_lx} : mid_addr;
    assign frame_wdata = load_acc ? {i_in.in_red, i_in.in_green, i_in.in_blue} : res_pix;
    assign scratch_we  = (r_state == S_B_WR) && !r_pass;

    isb_ram u_frame (
        .i_clk   (i_clk),
        .i_we    (frame_we),
        .i_waddr (frame_waddr),
        .i_wdata (frame_wdata),
        .i_raddr (frame_raddr),
        .o_rdata (frame_rdata)
    );

    isb_ram u_scratch (
        .i_clk   (i_clk),
        .i_we    (scratch_we),
        .i_waddr (mid_addr),
        .i_wdata (res_pix),
        .i_raddr (rd_addr),
        .o_rdata (scratch_rdata)
    );

    assign comp_sel = 2'd2 - r_comp;
    assign tp = r_p[comp_sel * COMPONENT_BITS +: COMPONENT_BITS];
    assign tm = r_m[comp_sel * COMPONENT_BITS +: COMPONENT_BITS];
    assign tq = r_q[comp_sel * COMPONENT_BITS +: COMPONENT_BITS];
    assign tap_req = '{start: (r_state == S_B_MUL), hp: hp, hq: hq};

    isb_tap u_tap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (tap_req),
        .i_weight (r_weight),
        .i_p      (tp),
        .i_m      (tm),
        .i_q      (tq),
        .o_done   (tap_done),
        .o_result (tap_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (fetch_acc) begin
                    n_state = r_valid ? S_FETCH : S_OUT;
                end else if (load_acc && lx_end && ly_end) begin
                    n_state = S_B_RD0;
                end
            end
            S_FETCH:  n_state = S_OUT;
            S_OUT:    if (o_out.ready) n_state = S_IDLE;
            S_B_RD0:  n_state = S_B_RD1;
            S_B_RD1:  n_state = S_B_RD2;
            S_B_RD2:  n_state = S_B_RD3;
            S_B_RD3:  n_state = S_B_MUL;
            S_B_MUL:  n_state = S_B_WAIT;
            S_B_WAIT: if (tap_done) n_state = (r_comp == 2'd2) ? S_B_WR : S_B_MUL;
            S_B_WR: begin
                if (bx_end && by_end && r_pass && (r_round == ROUND_BITS'(ROUNDS - 1))) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_B_RD0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
            r_width  <= WIDTH_MAX_SZ;
            r_height <= HEIGHT_MAX_SZ;
            r_lx <= '0;
            r_ly <= '0;
            r_rx <= '0;
            r_ry <= '0;
            r_bx <= '0;
            r_by <= '0;
            r_valid <= 1'b0;
            r_pass  <= 1'b0;
            r_round <= '0;
            r_comp  <= '0;
        end else begin
            if (cfg_acc) begin
                case (t_reg_index'(i_cfg.index))
                    REG_WEIGHT: r_weight <= i_cfg.data;
                    REG_WIDTH: begin
                        r_width <= clamp_size(i_cfg.data[SIZE_BITS-1:0], WIDTH_MAX_SZ);
                        r_lx <= '0;
                        r_ly <= '0;
                        r_rx <= '0;
                        r_ry <= '0;
                        r_valid <= 1'b0;
                    end
                    REG_HEIGHT: begin
                        r_height <= clamp_size(i_cfg.data[SIZE_BITS-1:0], HEIGHT_MAX_SZ);
                        r_lx <= '0;
                        r_ly <= '0;
                        r_rx <= '0;
                        r_ry <= '0;
                        r_valid <= 1'b0;
                    end
                    default: r_valid <= r_valid;
                endcase
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (load_acc) begin
                            r_valid <= 1'b0;
                            if (lx_end) begin
                                r_lx <= '0;
                                r_ly <= ly_end ? '0 : r_ly + Y_BITS'(1);
                            end else begin
                                r_lx <= r_lx + X_BITS'(1);
                            end
                            if (lx_end && ly_end) begin
                                r_rx <= '0;
                                r_ry <= '0;
                                r_bx <= '0;
                                r_by <= '0;
                                r_pass <= 1'b0;
                                r_round <= '0;
                                r_comp <= '0;
                            end
                        end
                    end
                    S_FETCH: begin
                        if (rx_end) begin
                            r_rx <= '0;
                            r_ry <= ry_end ? '0 : r_ry + Y_BITS'(1);
                        end else begin
                            r_rx <= r_rx + X_BITS'(1);
                        end
                    end
                    S_B_WAIT: begin
                        if (tap_done) begin
                            r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                        end
                    end
                    S_B_WR: begin
                        if (bx_end) begin
                            r_bx <= '0;
                            r_by <= by_end ? '0 : r_by + Y_BITS'(1);
                        end else begin
                            r_bx <= r_bx + X_BITS'(1);
                        end
                        if (bx_end && by_end) begin
                            r_pass <= !r_pass;
                            if (r_pass) begin
                                if (r_round == ROUND_BITS'(ROUNDS - 1)) begin
                                    r_valid <= 1'b1;
                                end else begin
                                    r_round <= r_round + ROUND_BITS'(1);
                                end
                            end
                        end
                    end
                    default: r_valid <= r_valid;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_out <= '0;
                r_last <= 1'b0;
                r_ready_flag <= 1'b0;
            end
            S_FETCH: begin
                r_out <= frame_rdata;
                r_last <= rx_end && ry_end;
                r_ready_flag <= 1'b1;
            end
            S_B_RD1: r_m <= src_data;
            S_B_RD2: r_p <= src_data;
            S_B_RD3: r_q <= src_data;
            S_B_WAIT: if (tap_done) r_res[r_comp] <= tap_res;
            default: r_last <= r_last;
        endcase
    end

    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.out_red     = r_out[PIX_BITS-1 -: COMPONENT_BITS];
    assign o_out.out_green   = r_out[2*COMPONENT_BITS-1 -: COMPONENT_BITS];
    assign o_out.out_blue    = r_out[COMPONENT_BITS-1:0];
    assign o_out.last_pixel  = r_last;
    assign o_out.frame_ready = r_ready_flag;

    `ISB_ASSERT(a_no_frame_zero, i_clk, i_rst_n, (o_out.valid && !o_out.frame_ready) |-> ((o_out.out_red == '0) && (o_out.out_green == '0) && (o_out.out_blue == '0) && !o_out.last_pixel), "fetch without a frame returned data")
    `ISB_ASSERT(a_load_in_range, i_clk, i_rst_n, ({1'b0, r_lx} < r_width) && ({1'b0, r_ly} < r_height), "load position outside the frame")
    `ISB_ASSERT(a_blur_in_range, i_clk, i_rst_n, (r_state != S_IDLE) |-> (({1'b0, r_bx} < r_width) && ({1'b0, r_by} < r_height)), "blur position outside the frame")
    `ISB_ASSERT(a_tap_done_wait, i_clk, i_rst_n, tap_done |-> (r_state == S_B_WAIT), "tap result arrived outside its wait state")
endmodule
`default_nettype wire
